### rtl/core/crm_pkg.sv
`default_nettype none

package crm_pkg;

   localparam int MAX_PORTS  = 8;
   localparam int STRIDE     = 8;
   localparam int MATRIX_W   = 64;
   localparam int PAIRS_W    = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [MATRIX_W-1:0] matrix_type;
   typedef logic [PAIRS_W-1:0]  pairs_type;

   typedef enum logic [1:0] {
      MODE_FIXED       = 2'd0,
      MODE_ROUND_ROBIN = 2'd1,
      MODE_ISLIP       = 2'd2
   } mode_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE_ADDR = '0;

endpackage

`default_nettype wire

### rtl/core/crm_if.sv
`default_nettype none

interface crm_req_if;
   logic                valid;
   logic                ready;
   crm_pkg::matrix_type request_matrix;

   modport source (output valid, output request_matrix, input ready);
   modport sink   (input valid, input request_matrix, output ready);
endinterface

interface crm_rsp_if;
   logic                valid;
   logic                ready;
   crm_pkg::matrix_type match_matrix;
   crm_pkg::pairs_type  matched_pairs;

   modport source (output valid, output match_matrix, output matched_pairs, input ready);
   modport sink   (input valid, input match_matrix, input matched_pairs, output ready);
endinterface

`default_nettype wire

### rtl/core/crossbar_round_robin_matcher.sv
// An input register and a result register lie between item accept and result valid.
// Throughput: one request matrix per cycle unless rsp.ready stalls; grant and
// accept arbitration and the pointer update all complete in the single stage
// between the two registers. Reset (synchronous, active high): pipeline empty, all
// grant and accept pointers zero, mode register zero (MODE_FIXED).
`default_nettype none

module crossbar_round_robin_matcher #(
   parameter int PORTS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   crm_req_if.sink                             req,
   crm_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [crm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [crm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [crm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   import crm_pkg::*;

   localparam int PW = $clog2(PORTS);

   logic [1:0] mode_raw_ff;
   mode_type   mode;

   logic       req_vld_ff;
   matrix_type req_ff;
   logic       rsp_vld_ff;
   matrix_type match_ff;
   pairs_type  pairs_ff;

   logic [PW-1:0] gnt_ptr_ff [PORTS];
   logic [PW-1:0] gnt_ptr_in [PORTS];
   logic [PW-1:0] acc_ptr_ff [PORTS];
   logic [PW-1:0] acc_ptr_in [PORTS];

   logic          gnt_vld [PORTS];
   logic [PW-1:0] gnt_idx [PORTS];
   logic          acc_vld [PORTS];
   logic [PW-1:0] acc_out [PORTS];

   matrix_type match_in;
   pairs_type  pairs_in;

   logic advance;
   logic fire;
   logic csr_wr;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & (csr_paddr == CSR_MODE_ADDR);
   assign mode       = mode_type'(mode_raw_ff);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_MODE_ADDR) begin
         csr_prdata[1:0] = mode_raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_raw_ff <= 2'd0;
      end else if (csr_wr) begin
         mode_raw_ff <= csr_pwdata[1:0];
      end
   end

   // handshake
   assign advance   = ~rsp_vld_ff | rsp.ready;
   assign fire      = req_vld_ff & advance;
   assign req.ready = ~req_vld_ff | advance;

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.match_matrix  = match_ff;
   assign rsp.matched_pairs = pairs_ff;

   // grant, accept and pointer update
   always_comb begin
      int cand;
      int cnt;
      cand = 0;
      cnt  = 0;
      match_in = '0;

      for (int o = 0; o < PORTS; o++) begin
         gnt_vld[o] = 1'b0;
         gnt_idx[o] = '0;
         for (int k = 0; k < PORTS; k++) begin
            cand = int'(gnt_ptr_ff[o]) + k;
            if (cand >= PORTS) begin
               cand = cand - PORTS;
            end
            if (!gnt_vld[o] && req_ff[cand*STRIDE + o]) begin
               gnt_vld[o] = 1'b1;
               gnt_idx[o] = PW'(cand);
            end
         end
      end

      for (int i = 0; i < PORTS; i++) begin
         acc_vld[i]    = 1'b0;
         acc_out[i]    = '0;
         acc_ptr_in[i] = acc_ptr_ff[i];
         for (int k = 0; k < PORTS; k++) begin
            cand = int'(acc_ptr_ff[i]) + k;
            if (cand >= PORTS) begin
               cand = cand - PORTS;
            end
            if (!acc_vld[i] && gnt_vld[cand] && (gnt_idx[cand] == PW'(i))) begin
               acc_vld[i] = 1'b1;
               acc_out[i] = PW'(cand);
            end
         end
         if (acc_vld[i]) begin
            match_in[i*STRIDE + int'(acc_out[i])] = 1'b1;
            cnt = cnt + 1;
            acc_ptr_in[i] = (int'(acc_out[i]) == PORTS-1) ? '0 : acc_out[i] + 1'b1;
         end
      end
      pairs_in = PAIRS_W'(cnt);

      for (int o = 0; o < PORTS; o++) begin
         gnt_ptr_in[o] = gnt_ptr_ff[o];
         case (mode)
            MODE_ROUND_ROBIN: begin
               if (gnt_vld[o]) begin
                  gnt_ptr_in[o] = (int'(gnt_idx[o]) == PORTS-1) ? '0 : gnt_idx[o] + 1'b1;
               end
            end
            MODE_ISLIP: begin
               if (gnt_vld[o] && acc_vld[gnt_idx[o]] && (acc_out[gnt_idx[o]] == PW'(o))) begin
                  gnt_ptr_in[o] = (int'(gnt_idx[o]) == PORTS-1) ? '0 : gnt_idx[o] + 1'b1;
               end
            end
            default: begin
               gnt_ptr_in[o] = gnt_ptr_ff[o];
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req.ready) begin
         req_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_ff <= req.request_matrix;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         match_ff <= match_in;
         pairs_ff <= pairs_in;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PORTS; p++) begin
            gnt_ptr_ff[p] <= '0;
            acc_ptr_ff[p] <= '0;
         end
      end else if (fire) begin
         for (int p = 0; p < PORTS; p++) begin
            gnt_ptr_ff[p] <= gnt_ptr_in[p];
            acc_ptr_ff[p] <= acc_ptr_in[p];
         end
      end
   end

endmodule

`default_nettype wire
